// ===== sv/ldw_pkg.sv =====
package ldw_pkg;

  // Fixed field widths of the stream.
  localparam int VALUE_BITS = 12;
  localparam int POS_BITS   = 48;

  // One table word: sighting flag and global position of the last sighting.
  typedef struct packed {
    logic                seen;
    logic [POS_BITS-1:0] pos;
  } ldw_entry_t;

  // Write request into the position table.
  typedef struct packed {
    logic       en;
    ldw_entry_t data;
  } ldw_wr_t;

endpackage

// ===== sv/longest_distinct_window_unit.sv =====
// Channel | Ports                                   | Direction | Handshake
// input   | in_value[11:0], in_seq_end              | in        | in_valid / in_ready
// result  | out_window_len, out_best_len, out_seq_done | out    | out_valid / out_ready
//
// One request per cycle sustained while results are taken. A result reaches the
// out_ ports through the evaluate stage and the output register: the table
// read issues at the accept edge, then evaluate and write back fill the output.
// A value repeated in the next request is forwarded from the evaluate stage.
// After reset every table entry is swept to unseen; in_ready is low meanwhile.
// A stalled result holds in the output register; input stalls once both are full.
module longest_distinct_window_unit import ldw_pkg::*; #(
  parameter int KEY_BITS = 12,
  parameter int LEN_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_seq_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEN_BITS-1:0]   out_window_len,
  output logic [LEN_BITS-1:0]   out_best_len,
  output logic                  out_seq_done
);

  logic                in_key;
  logic [KEY_BITS-1:0] key;
  logic                accept;

  // Key is the low KEY_BITS bits of the value, zero-extended if wider.
  generate
    if (KEY_BITS <= VALUE_BITS) begin : g_key_trunc
      assign key = in_value[KEY_BITS-1:0];
    end else begin : g_key_ext
      assign key = {{(KEY_BITS-VALUE_BITS){1'b0}}, in_value};
    end
  endgenerate

  // Evaluate stage registers.
  logic                s1_valid_r;
  logic [KEY_BITS-1:0] s1_key_r;
  logic [POS_BITS-1:0] s1_pos_r;
  logic                s1_last_r;
  logic                fwd_r;
  logic [POS_BITS-1:0] fwd_pos_r;
  logic                s1_adv;

  // Global position of the next request.
  logic [POS_BITS-1:0] pos_r;

  // Output register.
  logic                out_valid_r;
  logic [LEN_BITS-1:0] out_win_r;
  logic [LEN_BITS-1:0] out_best_r;
  logic                out_done_r;

  logic                clr_busy;
  ldw_entry_t          rd_data;
  ldw_entry_t          entry;
  ldw_wr_t             wr;
  logic [LEN_BITS-1:0] win_len;
  logic [LEN_BITS-1:0] best_len;

  assign in_key   = 1'b0;
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready && !in_key;

  // Write back the current position for the evaluated key.
  assign wr.en       = s1_adv;
  assign wr.data     = '{seen: 1'b1, pos: s1_pos_r};

  // Take the pending write-back over the stale table word.
  assign entry = fwd_r ? ldw_entry_t'{seen: 1'b1, pos: fwd_pos_r} : rd_data;

  ldw_table #(
    .KEY_BITS (KEY_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (key),
    .rd_data  (rd_data),
    .wr       (wr),
    .wr_addr  (s1_key_r),
    .clr_busy (clr_busy)
  );

  ldw_eval #(
    .LEN_BITS (LEN_BITS)
  ) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (s1_adv),
    .entry    (entry),
    .pos      (s1_pos_r),
    .last     (s1_last_r),
    .win_len  (win_len),
    .best_len (best_len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        pos_r      <= pos_r + 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and note a same-key write-back landing this edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r  <= key;
      s1_pos_r  <= pos_r;
      s1_last_r <= in_seq_end;
      fwd_r     <= s1_adv && (s1_key_r == key);
      fwd_pos_r <= s1_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_win_r  <= win_len;
      out_best_r <= best_len;
      out_done_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_len = out_win_r;
  assign out_best_len   = out_best_r;
  assign out_seq_done   = out_done_r;

endmodule

// ===== sv/ldw_table.sv =====
module ldw_table import ldw_pkg::*; #(
  parameter int KEY_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [KEY_BITS-1:0] rd_addr,
  output ldw_entry_t          rd_data,
  input  ldw_wr_t             wr,
  input  logic [KEY_BITS-1:0] wr_addr,
  output logic                clr_busy
);

  localparam int Depth = 1 << KEY_BITS;

  ldw_entry_t          mem [Depth];
  ldw_entry_t          rd_data_r;
  logic                clr_busy_r;
  logic [KEY_BITS-1:0] clr_addr_r;

  // Sweep every entry to unseen after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ===== sv/ldw_eval.sv =====
module ldw_eval import ldw_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  ldw_entry_t          entry,
  input  logic [POS_BITS-1:0] pos,
  input  logic                last,
  output logic [LEN_BITS-1:0] win_len,
  output logic [LEN_BITS-1:0] best_len
);

  localparam logic [POS_BITS-1:0] LenMax =
    {{(POS_BITS-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};

  logic [POS_BITS-1:0] ws_r, ws_nxt;
  logic [LEN_BITS-1:0] best_r, best_nxt;
  logic [POS_BITS-1:0] back_last, back_start, ws_eff, span;
  logic                move;
  logic [LEN_BITS-1:0] len, best_cur;

  always_comb begin
    back_last  = pos - entry.pos;
    back_start = pos - ws_r;
    move       = entry.seen && (back_last <= back_start);
    ws_eff     = move ? (entry.pos + 1'b1) : ws_r;
    span       = move ? (back_last - 1'b1) : back_start;
    len        = (span >= LenMax) ? {LEN_BITS{1'b1}} : (span[LEN_BITS-1:0] + 1'b1);
    best_cur   = (len > best_r) ? len : best_r;
    // Start the next sequence just past this item.
    ws_nxt     = last ? (pos + 1'b1) : ws_eff;
    best_nxt   = last ? '0 : best_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      best_r <= '0;
    end else if (adv) begin
      ws_r   <= ws_nxt;
      best_r <= best_nxt;
    end
  end

  assign win_len  = len;
  assign best_len = best_cur;

endmodule

// ===== sv/ldw_checker.sv =====
module ldw_checker import ldw_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [VALUE_BITS-1:0] in_value,
  input logic                  in_seq_end,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEN_BITS-1:0]   out_window_len,
  input logic [LEN_BITS-1:0]   out_best_len,
  input logic                  out_seq_done
);

  // Hold a waiting request unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_value) && $stable(in_seq_end))
    else $error("waiting request changed");

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_len)
      && $stable(out_best_len) && $stable(out_seq_done))
    else $error("stalled result changed");

  // Every result counts this item, and the best covers the current window.
  a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_window_len != '0) && (out_best_len >= out_window_len))
    else $error("window length out of order");

  // Table sweep keeps input closed and no result pending right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("activity right after reset");

  // A result can only follow an accepted request.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2)
      || $past(in_valid && in_ready, 3) || $past(out_valid && out_ready))
    else $error("result without request");

endmodule

bind longest_distinct_window_unit ldw_checker #(
  .LEN_BITS (LEN_BITS)
) u_ldw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_value       (in_value),
  .in_seq_end     (in_seq_end),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_window_len (out_window_len),
  .out_best_len   (out_best_len),
  .out_seq_done   (out_seq_done)
);
